### design/chl_pkg.sv
`timescale 1ns / 1ps

package chl_pkg;

	// Histogram geometry and number formats.
	localparam int MAX_BINS       = 16;
	localparam int BINS_LOG2_MAX  = $clog2(MAX_BINS);
	localparam int DEPTH          = MAX_BINS * MAX_BINS * MAX_BINS;
	localparam int ADDR_W         = $clog2(DEPTH);
	localparam int CNT_W          = ADDR_W + 1;
	localparam int COUNT_BITS     = 20;
	localparam int PROB_FRAC_BITS = 24;
	localparam int PROB_W         = PROB_FRAC_BITS + 1;
	localparam int RATE_W         = 17;
	localparam int SUM_W          = ADDR_W + COUNT_BITS;
	localparam int DIVD_W         = PROB_FRAC_BITS + RATE_W;
	localparam int FACT_W         = PROB_FRAC_BITS + 2;
	localparam int BINS_W         = 3;
	localparam int CH_W           = 8;
	localparam int FUNC_W         = 3;
	localparam int CFG_IDX_W      = 2;

	localparam logic [RATE_W-1:0] RATE_ONE = RATE_W'(1) << (RATE_W - 1);
	localparam logic [PROB_W-1:0] PROB_ONE = PROB_W'(1) << PROB_FRAC_BITS;
	localparam logic [FACT_W-1:0] FACT_MAX = FACT_W'(1) << (FACT_W - 1);

	// Operation codes of the func field.
	typedef logic [FUNC_W-1:0] func_t;
	localparam func_t FN_ADD_FG = 3'd0;
	localparam func_t FN_ADD_BG = 3'd1;
	localparam func_t FN_QUERY  = 3'd2;
	localparam func_t FN_UPDATE = 3'd3;
	localparam func_t FN_INIT   = 3'd4;
	localparam func_t FN_CLEAR  = 3'd5;

	// Register indexes of the configuration port.
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t REG_BINS    = 2'd0;
	localparam cfg_idx_t REG_RATE_FG = 2'd1;
	localparam cfg_idx_t REG_RATE_BG = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_CLR,
		ST_SUM,
		ST_DIV,
		ST_BLEND,
		ST_RESP
	} state_t;

	// How one side is blended in the current pass.
	typedef struct packed {
		logic empty;
		logic rate_one;
	} blend_ctl_t;

	function automatic logic [BINS_W-1:0] eff_bins(input logic [BINS_W-1:0] b);
		logic [BINS_W-1:0] r;
		r = b;
		if (b == '0) begin
			r = BINS_W'(1);
		end else if (b > BINS_W'(BINS_LOG2_MAX)) begin
			r = BINS_W'(BINS_LOG2_MAX);
		end
		return r;
	endfunction

	function automatic logic [ADDR_W-1:0] bin_index(input logic [CH_W-1:0] c0,
			input logic [CH_W-1:0] c1, input logic [CH_W-1:0] c2,
			input logic [BINS_W-1:0] b);
		logic [3:0] s;
		logic [ADDR_W-1:0] i0;
		logic [ADDR_W-1:0] i1;
		logic [ADDR_W-1:0] i2;
		s  = 4'd8 - 4'(b);
		i0 = ADDR_W'(c0 >> s);
		i1 = ADDR_W'(c1 >> s);
		i2 = ADDR_W'(c2 >> s);
		return (i0 << (5'(b) * 5'd2)) | (i1 << b) | i2;
	endfunction

	function automatic logic [PROB_W-1:0] flat_prob(input logic [BINS_W-1:0] b);
		return PROB_ONE >> (5'(b) * 5'd3);
	endfunction

	function automatic logic [CNT_W-1:0] bin_total(input logic [BINS_W-1:0] b);
		return CNT_W'(1) << (5'(b) * 5'd3);
	endfunction

	function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] x);
		return (x == '1) ? x : x + COUNT_BITS'(1);
	endfunction

	function automatic logic [RATE_W-1:0] clamp_rate(input logic [RATE_W-1:0] r);
		return (r > RATE_ONE) ? RATE_ONE : r;
	endfunction

endpackage

### design/chl_ram.sv
`timescale 1ns / 1ps

module chl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port; read data holds between reads.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### design/chl_div.sv
`timescale 1ns / 1ps

module chl_div import chl_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIVD_W-1:0] dividend,
	input  logic [SUM_W-1:0]  divisor,
	output logic              busy,
	output logic [DIVD_W-1:0] quotient
);

	localparam int STEP_W = $clog2(DIVD_W + 1);

	logic [SUM_W-1:0]  rem_q;
	logic [DIVD_W-1:0] quo_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic [SUM_W:0]    trial;
	logic              fits;

	// Restoring division, one quotient bit per cycle.
	assign trial = {rem_q, quo_q[DIVD_W-1]};
	assign fits  = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= STEP_W'(DIVD_W);
		end else if (busy_q) begin
			step_q <= step_q - STEP_W'(1);
			if (step_q == STEP_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? SUM_W'(trial - {1'b0, divisor}) : SUM_W'(trial);
			quo_q <= {quo_q[DIVD_W-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

	// A new division is started only when the last one has finished.
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q) else $error("divider restarted while busy");

endmodule

### design/chl_blend.sv
`timescale 1ns / 1ps

module chl_blend import chl_pkg::*; (
	input  logic                  clk,
	input  logic [PROB_W-1:0]     h,
	input  logic [COUNT_BITS-1:0] cnt,
	input  logic [RATE_W-1:0]     keep,
	input  logic [FACT_W-1:0]     factor,
	input  blend_ctl_t            ctl,
	input  logic [PROB_W-1:0]     uniform,
	output logic [PROB_W-1:0]     new_h
);

	localparam int PH_W = PROB_W + RATE_W;
	localparam int PC_W = COUNT_BITS + FACT_W;

	logic [PH_W-1:0]   prod_h_s2;
	logic [PC_W-1:0]   prod_c_s2;
	logic [PROB_W-1:0] h_s2;
	logic [PC_W:0]     v;

	// Both products are registered before the add.
	always_ff @(posedge clk) begin
		prod_h_s2 <= PH_W'(h) * PH_W'(keep);
		prod_c_s2 <= PC_W'(cnt) * PC_W'(factor);
		h_s2      <= h;
	end

	// Decayed value plus scaled count, saturated at one.
	assign v = (PC_W + 1)'(prod_h_s2[PH_W-1:RATE_W-1]) + (PC_W + 1)'(prod_c_s2);

	always_comb begin
		if (ctl.empty) begin
			new_h = ctl.rate_one ? uniform : h_s2;
		end else if (v > (PC_W + 1)'(PROB_ONE)) begin
			new_h = PROB_ONE;
		end else begin
			new_h = v[PROB_W-1:0];
		end
	end

endmodule

### design/color_histogram_learner_core.sv
`timescale 1ns / 1ps

// Foreground/background color histogram learner. Counts and learned Q1.24
// probabilities of both sides live in two 4096-entry memories with a
// registered read. For an add, query or unused item the bin is read in the
// cycle of the transfer and written back in the next; the result is loaded
// once the output is free. Clear counts runs the transfer, a sweep that
// clears one entry per cycle, and the response. Update and initialize run
// the transfer, a summing sweep over the counts of the n = 2^(3*bins_log2)
// bins, a serial divide per side (both in parallel), a blending sweep over
// every entry that also zeroes the counts, and the response. After reset and
// after every write of bins_log2 a clearing pass over all 4096 entries runs,
// during which no item is taken. Every item returns exactly one result
// unless bins_log2 is written before it completes; a result waiting in the
// output register does not keep the next item from being accepted.
module color_histogram_learner_core import chl_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [RATE_W-1:0]     cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [FUNC_W-1:0]     func,
	input  logic [CH_W-1:0]       channel_zero,
	input  logic [CH_W-1:0]       channel_one,
	input  logic [CH_W-1:0]       channel_two,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [PROB_W-1:0]     prob_foreground,
	output logic [PROB_W-1:0]     prob_background
);

	state_t state_q, state_d;
	logic [CNT_W-1:0]  addr_q, addr_d;
	logic [BINS_W-1:0] bins_q;
	logic [RATE_W-1:0] rate_fg_q, rate_bg_q, lr_fg_q, lr_bg_q;
	logic [ADDR_W-1:0] idx_q, addr_s1, addr_s2;
	func_t             func_q;
	logic              fill_q, resp_q, v_s1, v_s2, out_valid_q;
	logic [SUM_W-1:0]  sum_fg_q, sum_bg_q;
	logic [PROB_W-1:0] prob_fg_q, prob_bg_q;

	logic [BINS_W-1:0] b_eff;
	logic [CNT_W-1:0]  n_bins;
	logic [PROB_W-1:0] uni;
	logic [ADDR_W-1:0] idx_in;
	logic              accept, out_free, cfg_bins_wr, pass_rd, out_load;

	logic                    cnt_we, cnt_re, lrn_we, lrn_re;
	logic [ADDR_W-1:0]       cnt_waddr, cnt_raddr, lrn_waddr, lrn_raddr;
	logic [2*COUNT_BITS-1:0] cnt_wdata, cnt_rdata;
	logic [2*PROB_W-1:0]     lrn_wdata, lrn_rdata;

	logic              div_start, busy_fg, busy_bg;
	logic [DIVD_W-1:0] quo_fg, quo_bg;
	logic [FACT_W-1:0] fact_fg, fact_bg;
	logic [PROB_W-1:0] new_fg, new_bg;
	blend_ctl_t        ctl_fg, ctl_bg;

	assign b_eff       = eff_bins(bins_q);
	assign n_bins      = bin_total(b_eff);
	assign uni         = flat_prob(b_eff);
	assign idx_in      = bin_index(channel_zero, channel_one, channel_two, b_eff);
	assign cfg_bins_wr = cfg_we && (cfg_index == REG_BINS);
	assign in_stall    = (state_q != ST_IDLE) || cfg_bins_wr;
	assign accept      = in_valid && !in_stall;
	assign out_free    = !out_valid_q || !out_stall;

	// Count store: foreground in the upper half, background in the lower.
	chl_ram #(.WIDTH(2 * COUNT_BITS), .DEPTH(DEPTH)) u_cnt_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.re    (cnt_re),
		.raddr (cnt_raddr),
		.rdata (cnt_rdata)
	);

	// Learned store, same split.
	chl_ram #(.WIDTH(2 * PROB_W), .DEPTH(DEPTH)) u_lrn_ram (
		.clk   (clk),
		.we    (lrn_we),
		.waddr (lrn_waddr),
		.wdata (lrn_wdata),
		.re    (lrn_re),
		.raddr (lrn_raddr),
		.rdata (lrn_rdata)
	);

	// Reciprocal factors lr * 2^24 / sum for both sides.
	chl_div u_div_fg (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (DIVD_W'(lr_fg_q) << PROB_FRAC_BITS),
		.divisor  (sum_fg_q),
		.busy     (busy_fg),
		.quotient (quo_fg)
	);

	chl_div u_div_bg (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (DIVD_W'(lr_bg_q) << PROB_FRAC_BITS),
		.divisor  (sum_bg_q),
		.busy     (busy_bg),
		.quotient (quo_bg)
	);

	// A factor at or above 2^25 saturates any nonzero count anyway.
	assign fact_fg = (quo_fg > DIVD_W'(FACT_MAX)) ? FACT_MAX : quo_fg[FACT_W-1:0];
	assign fact_bg = (quo_bg > DIVD_W'(FACT_MAX)) ? FACT_MAX : quo_bg[FACT_W-1:0];

	assign ctl_fg.empty    = (sum_fg_q == '0);
	assign ctl_fg.rate_one = (lr_fg_q == RATE_ONE);
	assign ctl_bg.empty    = (sum_bg_q == '0);
	assign ctl_bg.rate_one = (lr_bg_q == RATE_ONE);

	chl_blend u_blend_fg (
		.clk     (clk),
		.h       (lrn_rdata[2*PROB_W-1:PROB_W]),
		.cnt     (cnt_rdata[2*COUNT_BITS-1:COUNT_BITS]),
		.keep    (RATE_ONE - lr_fg_q),
		.factor  (fact_fg),
		.ctl     (ctl_fg),
		.uniform (uni),
		.new_h   (new_fg)
	);

	chl_blend u_blend_bg (
		.clk     (clk),
		.h       (lrn_rdata[PROB_W-1:0]),
		.cnt     (cnt_rdata[COUNT_BITS-1:0]),
		.keep    (RATE_ONE - lr_bg_q),
		.factor  (fact_bg),
		.ctl     (ctl_bg),
		.uniform (uni),
		.new_h   (new_bg)
	);

	// Next state and memory control.
	always_comb begin
		state_d   = state_q;
		addr_d    = addr_q;
		cnt_we    = 1'b0;
		cnt_waddr = idx_q;
		cnt_wdata = '0;
		cnt_re    = 1'b0;
		cnt_raddr = idx_in;
		lrn_we    = 1'b0;
		lrn_waddr = idx_q;
		lrn_wdata = {uni, uni};
		lrn_re    = 1'b0;
		lrn_raddr = idx_in;
		div_start = 1'b0;
		pass_rd   = 1'b0;
		out_load  = 1'b0;
		if (cfg_bins_wr) begin
			state_d = ST_CLR;
			addr_d  = '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cnt_re = 1'b1;
						lrn_re = 1'b1;
						addr_d = '0;
						case (func)
							FN_UPDATE, FN_INIT: state_d = ST_SUM;
							FN_CLEAR:           state_d = ST_CLR;
							default:            state_d = ST_EXEC;
						endcase
					end
				end
				ST_EXEC: begin
					if (func_q == FN_ADD_FG) begin
						cnt_we    = 1'b1;
						cnt_wdata = {sat_inc(cnt_rdata[2*COUNT_BITS-1:COUNT_BITS]),
							cnt_rdata[COUNT_BITS-1:0]};
					end else if (func_q == FN_ADD_BG) begin
						cnt_we    = 1'b1;
						cnt_wdata = {cnt_rdata[2*COUNT_BITS-1:COUNT_BITS],
							sat_inc(cnt_rdata[COUNT_BITS-1:0])};
					end
					if (out_free) begin
						out_load = 1'b1;
						state_d  = ST_IDLE;
					end
				end
				ST_CLR: begin
					cnt_we    = 1'b1;
					cnt_waddr = addr_q[ADDR_W-1:0];
					lrn_we    = fill_q;
					lrn_waddr = addr_q[ADDR_W-1:0];
					addr_d    = addr_q + CNT_W'(1);
					if (addr_q == CNT_W'(DEPTH - 1)) begin
						state_d = resp_q ? ST_RESP : ST_IDLE;
					end
				end
				ST_SUM: begin
					if (addr_q < n_bins) begin
						cnt_re    = 1'b1;
						cnt_raddr = addr_q[ADDR_W-1:0];
						pass_rd   = 1'b1;
						addr_d    = addr_q + CNT_W'(1);
					end else if (!v_s1) begin
						div_start = 1'b1;
						state_d   = ST_DIV;
					end
				end
				ST_DIV: begin
					if (!busy_fg && !busy_bg) begin
						state_d = ST_BLEND;
						addr_d  = '0;
					end
				end
				ST_BLEND: begin
					if (!addr_q[CNT_W-1]) begin
						cnt_re    = 1'b1;
						cnt_raddr = addr_q[ADDR_W-1:0];
						lrn_re    = 1'b1;
						lrn_raddr = addr_q[ADDR_W-1:0];
						pass_rd   = 1'b1;
						addr_d    = addr_q + CNT_W'(1);
					end else if (!v_s1 && !v_s2) begin
						state_d = ST_RESP;
					end
					// Write-back follows the read through the v_s1 and v_s2 stages; counts go to zero.
					if (v_s2) begin
						cnt_we    = 1'b1;
						cnt_waddr = addr_s2;
						lrn_we    = CNT_W'(addr_s2) < n_bins;
						lrn_waddr = addr_s2;
						lrn_wdata = {new_fg, new_bg};
					end
				end
				ST_RESP: begin
					if (out_free) begin
						out_load = 1'b1;
						state_d  = ST_IDLE;
					end
				end
				default: state_d = ST_IDLE;
			endcase
		end
	end

	// Control state, configuration and pass bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			addr_q      <= '0;
			fill_q      <= 1'b1;
			resp_q      <= 1'b0;
			bins_q      <= BINS_W'(4);
			rate_fg_q   <= RATE_W'(13107);
			rate_bg_q   <= RATE_W'(13107);
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			addr_q  <= addr_d;
			v_s1    <= pass_rd;
			v_s2    <= v_s1 && (state_q == ST_BLEND);
			if (cfg_we) begin
				case (cfg_index)
					REG_BINS:    bins_q    <= cfg_wdata[BINS_W-1:0];
					REG_RATE_FG: rate_fg_q <= cfg_wdata;
					REG_RATE_BG: rate_bg_q <= cfg_wdata;
					default:     ;
				endcase
			end
			if (cfg_bins_wr) begin
				fill_q <= 1'b1;
				resp_q <= 1'b0;
			end else if (accept) begin
				fill_q <= 1'b0;
				resp_q <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Item payload, sums and result registers.
	always_ff @(posedge clk) begin
		addr_s1 <= addr_q[ADDR_W-1:0];
		addr_s2 <= addr_s1;
		if (accept) begin
			func_q   <= func;
			idx_q    <= idx_in;
			sum_fg_q <= '0;
			sum_bg_q <= '0;
			lr_fg_q  <= (func == FN_INIT) ? RATE_ONE : clamp_rate(rate_fg_q);
			lr_bg_q  <= (func == FN_INIT) ? RATE_ONE : clamp_rate(rate_bg_q);
		end else if ((state_q == ST_SUM) && v_s1) begin
			sum_fg_q <= sum_fg_q + SUM_W'(cnt_rdata[2*COUNT_BITS-1:COUNT_BITS]);
			sum_bg_q <= sum_bg_q + SUM_W'(cnt_rdata[COUNT_BITS-1:0]);
		end
		if (out_load) begin
			if ((state_q == ST_EXEC) && (func_q == FN_QUERY)) begin
				prob_fg_q <= lrn_rdata[2*PROB_W-1:PROB_W];
				prob_bg_q <= lrn_rdata[PROB_W-1:0];
			end else begin
				prob_fg_q <= '0;
				prob_bg_q <= '0;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign prob_foreground = prob_fg_q;
	assign prob_background = prob_bg_q;

	// An accepted item always leaves the idle state.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != ST_IDLE) else $error("item accepted without leaving idle");

	// A result appears only from the execute or response step.
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_EXEC || state_q == ST_RESP))
		else $error("result raised from an unexpected state");

	// The summing sweep has drained before the dividers use the sums.
	a_sum_drained: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !v_s1 && state_q == ST_SUM)
		else $error("divide started with a count read in flight");

endmodule
